// ===== design/puc_pkg.sv =====
// Shared types, constants and codes of the playout underrun controller.
// No dependencies; every other design file imports this package.
package puc_pkg;

  localparam int FRAMES_W   = 10;
  localparam int FADE_W     = 15;
  localparam int REP_W      = 5;
  localparam int STREAK_W   = 2;
  localparam int EMPTY_W    = 2;
  localparam int GAIN_W     = 16;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [GAIN_W-1:0]   GAIN_UNITY        = 16'd32768;
  localparam logic [FADE_W-1:0]   FADE_GAIN_RESET   = 15'd26214;
  localparam logic [REP_W-1:0]    REPEAT_MAX_RESET  = 5'd16;
  localparam logic [STREAK_W-1:0] STREAK_NEED_RESET = 2'd3;
  localparam logic [STREAK_W-1:0] STREAK_SAT        = 2'd3;
  localparam logic [EMPTY_W-1:0]  EMPTY_SAT         = 2'd2;

  localparam logic [FRAMES_W-1:0] TARGET_DEFAULT = 10'd4;
  localparam logic [FRAMES_W-1:0] LOW_SMALL_MAX  = 10'd4;
  localparam logic [FRAMES_W-1:0] LOW_HALF_MAX   = 10'd8;
  localparam logic [FRAMES_W-1:0] LOW_FLOOR      = 10'd4;
  localparam logic [FRAMES_W-1:0] LOW_MIN        = 10'd1;
  localparam logic [3:0]          RESUME_MARGIN  = 4'd2;
  localparam logic [3:0]          RESUME_MUL     = 4'd11;
  localparam logic [3:0]          RESUME_ROUND   = 4'd4;
  // floor(x/10) = (x * 52429) >> 19 and floor(x/3) = (x * 43691) >> 17 over these ranges
  localparam logic [15:0]         RECIP_TEN      = 16'd52429;
  localparam int                  RECIP_TEN_SH   = 19;
  localparam logic [15:0]         RECIP_THREE    = 16'd43691;
  localparam int                  RECIP_THREE_SH = 17;

  typedef enum logic [ACT_W-1:0] {
    ACT_PLAY    = 2'd0,
    ACT_CONCEAL = 2'd1,
    ACT_REBUF   = 2'd2,
    ACT_FILL    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_GAIN   = 2'd0,
    CFG_REPEAT_MAX  = 2'd1,
    CFG_STREAK_NEED = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_DECIDE,
    ST_FADE
  } state_t;

  typedef struct packed {
    logic                frame_arrived;
    logic [FRAMES_W-1:0] buf_level;
    logic [FRAMES_W-1:0] tgt_depth;
    logic                realtime_stream;
    logic                is_playing;
    logic                anchor_ok;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [GAIN_W-1:0] conceal_gain_q15;
    logic [REP_W-1:0]  repeat_number;
    logic              rebuffer_started;
    logic              rebuffer_ended;
  } out_item_t;

  typedef struct packed {
    logic [FADE_W-1:0]   fade_gain_q15;
    logic [REP_W-1:0]    conceal_repeat_max;
    logic [STREAK_W-1:0] resume_streak_needed;
  } cfg_t;

  typedef struct packed {
    logic ge_resume;
    logic le_low;
  } lvl_t;

  typedef struct packed {
    logic             start;
    logic [REP_W-1:0] reps;
  } fade_req_t;

  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] gain;
  } fade_sts_t;

endpackage

// ===== design/puc_ifs.sv =====
// Channel interfaces of the playout underrun controller: tick status, result, register write.
// Depends on puc_pkg for field widths.
interface puc_in_if import puc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                frame_arrived;
  logic [FRAMES_W-1:0] buf_level;
  logic [FRAMES_W-1:0] tgt_depth;
  logic                realtime_stream;
  logic                is_playing;
  logic                anchor_ok;

  modport source (output valid, frame_arrived, buf_level, tgt_depth,
                  realtime_stream, is_playing, anchor_ok, input ready);
  modport sink   (input valid, frame_arrived, buf_level, tgt_depth,
                  realtime_stream, is_playing, anchor_ok, output ready);
endinterface

interface puc_out_if import puc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [GAIN_W-1:0] conceal_gain_q15;
  logic [REP_W-1:0]  repeat_number;
  logic              rebuffer_started;
  logic              rebuffer_ended;

  modport source (output valid, action, conceal_gain_q15, repeat_number,
                  rebuffer_started, rebuffer_ended, input ready);
  modport sink   (input valid, action, conceal_gain_q15, repeat_number,
                  rebuffer_started, rebuffer_ended, output ready);
endinterface

interface puc_cfg_if import puc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/playout_underrun_controller.sv =====
// Top level of the playout underrun controller: register file, sequencer and fade unit.
// Depends on puc_pkg, puc_ifs, puc_ctrl, puc_fade.
//
// Usage: one request on in_ch per playback tick carries the receiver status; the block
// answers with exactly one request on out_ch giving the action (play, conceal, rebuffer
// silence, silence fill), the fade gain, the repeat index and the rebuffer start/end flags.
// cfg_ch writes the fade gain, the repeat limit and the resume streak length; it is always
// ready and must be written only while no tick is in flight; the block does not enforce
// this. Index 3 is ignored. Per tick the status is latched, the level compare registered,
// the action decided and the fade unit started; the shared fade multiplier then runs as
// often as the repeat index of a concealment tick. in_ch.ready is high only while idle.
// Reset: the playout state clears, the registers return to 26214, 16 and 3, no result pending.
// Stall: a result waits in the output register while out_ch.ready is low; the next tick is
// still accepted and computed, and its result holds inside until the register frees.
module playout_underrun_controller import puc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  puc_in_if.sink    in_ch,
  puc_out_if.source out_ch,
  puc_cfg_if.sink   cfg_ch
);

  cfg_t      cfg_r, cfg_nxt;
  in_item_t  in_item;
  out_item_t out_item;
  fade_req_t fade_req;
  fade_sts_t fade_sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FADE_GAIN:   cfg_nxt.fade_gain_q15        = cfg_ch.data[FADE_W-1:0];
        CFG_REPEAT_MAX:  cfg_nxt.conceal_repeat_max   = cfg_ch.data[REP_W-1:0];
        CFG_STREAK_NEED: cfg_nxt.resume_streak_needed = cfg_ch.data[STREAK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fade_gain_q15        <= FADE_GAIN_RESET;
      cfg_r.conceal_repeat_max   <= REPEAT_MAX_RESET;
      cfg_r.resume_streak_needed <= STREAK_NEED_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign in_item.frame_arrived   = in_ch.frame_arrived;
  assign in_item.buf_level       = in_ch.buf_level;
  assign in_item.tgt_depth       = in_ch.tgt_depth;
  assign in_item.realtime_stream = in_ch.realtime_stream;
  assign in_item.is_playing      = in_ch.is_playing;
  assign in_item.anchor_ok       = in_ch.anchor_ok;

  puc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item),
    .fade_req  (fade_req),
    .fade_sts  (fade_sts)
  );

  puc_fade u_fade (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (fade_req),
    .fade_gain_q15 (cfg_r.fade_gain_q15),
    .sts           (fade_sts)
  );

  assign out_ch.action           = out_item.action;
  assign out_ch.conceal_gain_q15 = out_item.conceal_gain_q15;
  assign out_ch.repeat_number    = out_item.repeat_number;
  assign out_ch.rebuffer_started = out_item.rebuffer_started;
  assign out_ch.rebuffer_ended   = out_item.rebuffer_ended;

endmodule

// ===== design/puc_level.sv =====
// Buffer level compare: resume level and low-water mark derived from the target depth.
// Depends on puc_pkg.
module puc_level import puc_pkg::*; (
  input  logic [FRAMES_W-1:0] buffered,
  input  logic [FRAMES_W-1:0] target,
  output lvl_t                lvl
);

  logic [FRAMES_W-1:0] tgt_eff;
  logic [10:0]         plus;
  logic [13:0]         scaled_num;
  logic [29:0]         scaled_prod;
  logic [10:0]         scaled;
  logic [10:0]         resume;
  logic [25:0]         third_prod;
  logic [FRAMES_W-1:0] third;
  logic [FRAMES_W-1:0] low;

  always_comb begin
    tgt_eff     = (target != '0) ? target : TARGET_DEFAULT;
    plus        = {1'b0, tgt_eff} + {7'd0, RESUME_MARGIN};
    scaled_num  = 14'({4'd0, tgt_eff} * {10'd0, RESUME_MUL}) + {10'd0, RESUME_ROUND};
    scaled_prod = {16'd0, scaled_num} * {14'd0, RECIP_TEN};
    scaled      = 11'(scaled_prod >> RECIP_TEN_SH);
    resume      = (plus > scaled) ? plus : scaled;

    third_prod  = {16'd0, target} * {10'd0, RECIP_THREE};
    third       = FRAMES_W'(third_prod >> RECIP_THREE_SH);
    priority if (target <= LOW_SMALL_MAX) begin
      low = (target != '0) ? target : LOW_MIN;
    end else if (target <= LOW_HALF_MAX) begin
      low = target >> 1;
    end else begin
      low = (third > LOW_FLOOR) ? third : LOW_FLOOR;
    end

    lvl.ge_resume = {1'b0, buffered} >= resume;
    lvl.le_low    = buffered <= low;
  end

endmodule

// ===== design/puc_fade.sv =====
// Iterative fade gain unit: one Q15 multiply and floor shift per cycle, repeated per repeat index.
// Depends on puc_pkg.
module puc_fade import puc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  fade_req_t         req,
  input  logic [FADE_W-1:0] fade_gain_q15,
  output fade_sts_t         sts
);

  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic [REP_W-1:0]  cnt_r, cnt_nxt;
  logic [30:0]       prod;

  always_comb begin
    prod     = {15'd0, gain_r} * {16'd0, fade_gain_q15};
    gain_nxt = gain_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      gain_nxt = GAIN_UNITY;
      cnt_nxt  = req.reps;
    end else if (cnt_r != '0) begin
      gain_nxt = prod[30:15];
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    gain_r <= gain_nxt;
  end

  assign sts.busy = cnt_r != '0;
  assign sts.gain = gain_r;

endmodule

// ===== design/puc_ctrl.sv =====
// Tick sequencer: latches the status, decides the action, updates the playout state,
// runs the fade unit and holds the result register. Depends on puc_pkg, puc_level.
module puc_ctrl import puc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  output fade_req_t fade_req,
  input  fade_sts_t fade_sts
);

  state_t              state_r, state_nxt;
  in_item_t            item_r;
  lvl_t                lvl, lvl_r;
  logic                rb_r, rb_nxt;
  logic [STREAK_W-1:0] st_r, st_nxt;
  logic [EMPTY_W-1:0]  er_r, er_nxt;
  logic [REP_W-1:0]    cr_r, cr_nxt;
  logic                hg_r, hg_nxt;
  action_t             act_r, act_nxt;
  logic [REP_W-1:0]    rep_r, rep_nxt;
  logic                started_r, started_nxt;
  logic                ended_r, ended_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;
  logic                live;
  logic [STREAK_W-1:0] st_tmp;
  logic [EMPTY_W-1:0]  er_tmp;
  logic                load;

  puc_level u_level (
    .buffered (item_r.buf_level),
    .target   (item_r.tgt_depth),
    .lvl      (lvl)
  );

  assign live = item_r.realtime_stream & item_r.is_playing & item_r.anchor_ok;

  always_comb begin
    rb_nxt      = rb_r;
    st_nxt      = st_r;
    er_nxt      = er_r;
    cr_nxt      = cr_r;
    hg_nxt      = hg_r;
    act_nxt     = act_r;
    rep_nxt     = rep_r;
    started_nxt = started_r;
    ended_nxt   = ended_r;
    st_tmp      = '0;
    er_tmp      = '0;
    if (state_r == ST_DECIDE) begin
      act_nxt     = ACT_FILL;
      rep_nxt     = '0;
      started_nxt = 1'b0;
      ended_nxt   = 1'b0;
      if (rb_r) begin
        if (!live) begin
          rb_nxt = 1'b0;
          st_nxt = '0;
        end else begin
          if (lvl_r.ge_resume) begin
            st_tmp = (st_r < STREAK_SAT) ? st_r + 1'b1 : st_r;
          end
          if (st_tmp >= cfg.resume_streak_needed) begin
            rb_nxt    = 1'b0;
            er_nxt    = '0;
            cr_nxt    = '0;
            st_nxt    = '0;
            ended_nxt = 1'b1;
          end else begin
            st_nxt = st_tmp;
          end
        end
      end
      if (rb_nxt) begin
        act_nxt = ACT_REBUF;
      end else if (item_r.frame_arrived) begin
        act_nxt = ACT_PLAY;
        cr_nxt  = '0;
        er_nxt  = '0;
        hg_nxt  = 1'b1;
      end else begin
        er_tmp = (er_nxt < EMPTY_SAT) ? er_nxt + 1'b1 : er_nxt;
        er_nxt = er_tmp;
        if (live && lvl_r.le_low && er_tmp >= EMPTY_SAT) begin
          rb_nxt      = 1'b1;
          st_nxt      = '0;
          cr_nxt      = cfg.conceal_repeat_max;
          started_nxt = 1'b1;
        end else if (hg_r && cr_nxt < cfg.conceal_repeat_max) begin
          act_nxt = ACT_CONCEAL;
          rep_nxt = cr_nxt;
          cr_nxt  = cr_nxt + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    fade_req      = '0;
    load          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        fade_req.start = 1'b1;
        fade_req.reps  = rep_nxt;
        state_nxt      = ST_FADE;
      end
      ST_FADE: begin
        if (!fade_sts.busy && (!out_valid_r || out_ready)) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_nxt.action           = act_r;
      out_nxt.conceal_gain_q15 = fade_sts.gain;
      out_nxt.repeat_number    = rep_r;
      out_nxt.rebuffer_started = started_r;
      out_nxt.rebuffer_ended   = ended_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rb_r        <= 1'b0;
      st_r        <= '0;
      er_r        <= '0;
      cr_r        <= '0;
      hg_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rb_r        <= rb_nxt;
      st_r        <= st_nxt;
      er_r        <= er_nxt;
      cr_r        <= cr_nxt;
      hg_r        <= hg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
    lvl_r     <= lvl;
    act_r     <= act_nxt;
    rep_r     <= rep_nxt;
    started_r <= started_nxt;
    ended_r   <= ended_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== design/puc_checker.sv =====
// Port-level checks of the playout underrun controller, bound to the top level.
// Depends on puc_pkg.
module puc_checker import puc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ACT_W-1:0]  action,
  input logic [GAIN_W-1:0] gain,
  input logic [REP_W-1:0]  rep,
  input logic              started,
  input logic              ended
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(gain) && $stable(rep))
    else $error("stalled result changed");

  a_unused_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && action != ACT_CONCEAL |-> gain == GAIN_UNITY && rep == '0)
    else $error("gain or repeat set outside concealment");

  a_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && started |-> action == ACT_FILL && !ended)
    else $error("rebuffer entry without silence fill");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a tick is in flight");

endmodule

bind playout_underrun_controller puc_checker u_puc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .action    (out_ch.action),
  .gain      (out_ch.conceal_gain_q15),
  .rep       (out_ch.repeat_number),
  .started   (out_ch.rebuffer_started),
  .ended     (out_ch.rebuffer_ended)
);
